// File: rtl/afmt_pkg.sv
// shared types and constants of the adc pair average ascii formatter
`timescale 1ns / 1ps
`default_nettype none

package afmt_pkg;

   // default conversion width
   localparam int SAMPLE_BITS_DEFAULT = 10;

   // width of the value handed to the formatter (covers hex and binary text)
   localparam int VAL_BITS = 12;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DISPLAY_MODE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLT_PLACES  = 2'd1;

   // display modes
   localparam logic [1:0] MODE_HEX  = 2'd0;
   localparam logic [1:0] MODE_DEC  = 2'd1;
   localparam logic [1:0] MODE_BIN  = 2'd2;
   localparam logic [1:0] MODE_VOLT = 2'd3;

   localparam logic [1:0] MODE_RESET   = MODE_HEX;
   localparam logic [2:0] PLACES_RESET = 3'd4;
   localparam logic [2:0] PLACES_MIN   = 3'd1;
   localparam logic [2:0] PLACES_MAX   = 3'd4;

   // characters and command bytes
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_POINT    = 8'h2E;
   localparam logic [7:0] HEX_ALPHA_GAP = 8'd7;
   localparam logic [7:0] CMD_NEXT_LINE = 8'hC0;

   // voltage scaling: value * 5 / 1023 volts
   localparam int VOLT_FULL_SCALE = 1023;
   localparam int VOLT_GAIN       = 5;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // one averaged value waiting to be formatted
   typedef struct packed {
      logic [VAL_BITS-1:0] value;
      logic [1:0]          mode;
      logic [2:0]          places;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_port_type;

endpackage

`default_nettype wire

// File: rtl/afmt_if.sv
// channel interfaces of the adc pair average ascii formatter
`timescale 1ns / 1ps
`default_nettype none

interface afmt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] sample_high;
   logic [1:0] sample_low;

   modport source (output valid, output sample_high, output sample_low, input ready);
   modport sink (input valid, input sample_high, input sample_low, output ready);
endinterface

interface afmt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_command;
   logic       last_char;

   modport source (output valid, output char_code, output is_command, output last_char,
                   input ready);
   modport sink (input valid, input char_code, input is_command, input last_char,
                 output ready);
endinterface

`default_nettype wire

// File: rtl/afmt_front.sv
// front end: config registers, pairing and averaging of samples
`timescale 1ns / 1ps
`default_nettype none

module afmt_front #(
   parameter int SAMPLE_BITS = afmt_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   afmt_req_if.sink                                 req_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [afmt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [afmt_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   input  wire logic                                q_full,
   output afmt_pkg::q_port_type                     q_push
);

   logic [1:0]             mode_ff, mode_in;
   logic [2:0]             places_ff, places_in;
   logic [SAMPLE_BITS-1:0] held_ff, held_in;
   logic                   have_first_ff, have_first_in;

   logic [afmt_pkg::VAL_BITS-1:0] raw;
   logic [SAMPLE_BITS-1:0]        sample;
   logic [SAMPLE_BITS:0]          sum;
   logic                          accept;
   logic                          places_ok;

   assign raw    = afmt_pkg::VAL_BITS'({req_chan.sample_high, req_chan.sample_low});
   assign sample = raw[SAMPLE_BITS-1:0];
   assign sum    = {1'b0, held_ff} + {1'b0, sample};

   // a first sample never pushes, so it may go in while the queue is full
   assign req_chan.ready = !q_full || !have_first_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   assign places_ok = (places_ff >= afmt_pkg::PLACES_MIN) && (places_ff <= afmt_pkg::PLACES_MAX);

   always_comb begin
      mode_in   = mode_ff;
      places_in = places_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            afmt_pkg::CSR_DISPLAY_MODE: mode_in   = csr_wdata[1:0];
            afmt_pkg::CSR_VOLT_PLACES:  places_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      held_in          = held_ff;
      have_first_in    = have_first_ff;
      q_push.valid     = 1'b0;
      q_push.item.value  = afmt_pkg::VAL_BITS'(sum[SAMPLE_BITS:1]);
      q_push.item.mode   = mode_ff;
      q_push.item.places = places_ff;
      if (accept) begin
         have_first_in = !have_first_ff;
         if (!have_first_ff) begin
            held_in = sample;
         end else begin
            // voltage text with places out of range yields nothing
            q_push.valid = !(mode_ff == afmt_pkg::MODE_VOLT && !places_ok);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= afmt_pkg::MODE_RESET;
         places_ff     <= afmt_pkg::PLACES_RESET;
         held_ff       <= '0;
         have_first_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         places_ff     <= places_in;
         held_ff       <= held_in;
         have_first_ff <= have_first_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/afmt_queue.sv
// short queue of averaged values between front and back
`timescale 1ns / 1ps
`default_nettype none

module afmt_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  afmt_pkg::q_port_type q_push,
   input  wire logic            q_pop,
   output logic                 q_full,
   output afmt_pkg::q_port_type q_head
);

   localparam int DEPTH      = afmt_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0]   PTR_LAST  = PTR_BITS'(DEPTH - 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(DEPTH);

   afmt_pkg::item_type slot_ff [DEPTH];

   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_full       = (count_ff == COUNT_MAX);
   assign q_head.valid = (count_ff != '0);
   assign q_head.item  = slot_ff[rd_ptr_ff];

   assign do_push = q_push.valid && !q_full;
   assign do_pop  = q_pop && q_head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/afmt_back.sv
// back end: character sequencer with one character step per cycle while the output is not stalled
`timescale 1ns / 1ps
`default_nettype none

module afmt_back (
   input  wire logic            clock,
   input  wire logic            reset,
   input  afmt_pkg::q_port_type q_head,
   output logic                 q_pop,
   afmt_rsp_if.source           rsp_chan
);

   localparam int VB = afmt_pkg::VAL_BITS;

   // largest quotient of one step: integer volts of a full-width value
   localparam int QUO_MAX = ((1 << VB) - 1) * afmt_pkg::VOLT_GAIN / afmt_pkg::VOLT_FULL_SCALE;

   logic               busy_ff, busy_in;
   afmt_pkg::item_type item_ff, item_in;
   logic [3:0]         pos_ff, pos_in;
   logic [VB-1:0]      rem_ff, rem_in;
   logic               started_ff, started_in;

   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_char_ff, out_char_in;
   logic       out_cmd_ff, out_cmd_in;
   logic       out_last_ff, out_last_in;

   logic       step;
   logic [7:0] ch;
   logic       cmd;
   logic       last;
   logic [VB-1:0] rem_step;
   logic          started_step;
   logic          started_now;

   logic [15:0] div_t;
   logic [15:0] div_d;
   logic [15:0] div_sub;
   logic [4:0]  quo;
   logic [3:0]  nib;
   logic [3:0]  bit_idx;

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      logic [7:0] c;
      c = afmt_pkg::CHAR_ZERO + 8'(n);
      if (n >= 4'd10) begin
         c = c + afmt_pkg::HEX_ALPHA_GAP;
      end
      return c;
   endfunction

   // dividend and divisor of this cycle's digit step
   always_comb begin
      div_t = 16'(rem_ff);
      div_d = 16'(afmt_pkg::VOLT_FULL_SCALE);
      if (item_ff.mode == afmt_pkg::MODE_DEC) begin
         case (pos_ff)
            4'd0:    div_d = 16'd1000;
            4'd1:    div_d = 16'd100;
            4'd2:    div_d = 16'd10;
            default: div_d = 16'd1;
         endcase
      end else if (pos_ff == 4'd0) begin
         div_t = 16'(item_ff.value) * 16'(afmt_pkg::VOLT_GAIN);
      end else begin
         div_t = 16'(rem_ff) * 16'd10;
      end
   end

   // one quotient digit by parallel compares against its multiples
   always_comb begin
      quo     = '0;
      div_sub = '0;
      for (int k = 1; k <= QUO_MAX; k++) begin
         if (div_t >= 16'(k) * div_d) begin
            quo     = 5'(k);
            div_sub = 16'(k) * div_d;
         end
      end
   end

   assign bit_idx     = 4'(VB - 1) - pos_ff;
   assign started_now = started_ff || (quo != 5'd0) || (pos_ff == 4'd3);

   always_comb begin
      ch           = afmt_pkg::CHAR_SPACE;
      cmd          = 1'b0;
      last         = 1'b0;
      rem_step     = rem_ff;
      started_step = started_ff;
      nib          = item_ff.value[3:0];
      unique case (item_ff.mode)
         afmt_pkg::MODE_HEX: begin
            case (pos_ff)
               4'd0:    nib = item_ff.value[11:8];
               4'd1:    nib = item_ff.value[7:4];
               default: nib = item_ff.value[3:0];
            endcase
            if (pos_ff == 4'd3) begin
               last = 1'b1;
            end else begin
               ch = hex_char(nib);
            end
         end
         afmt_pkg::MODE_DEC: begin
            if (pos_ff == 4'd4) begin
               last = 1'b1;
            end else begin
               started_step = started_now;
               rem_step     = VB'(div_t - div_sub);
               ch = started_now ? afmt_pkg::CHAR_ZERO + 8'(quo) : afmt_pkg::CHAR_SPACE;
            end
         end
         afmt_pkg::MODE_BIN: begin
            if (pos_ff < 4'd12) begin
               ch = afmt_pkg::CHAR_ZERO + 8'(item_ff.value[bit_idx]);
            end else if (pos_ff == 4'd12) begin
               ch  = afmt_pkg::CMD_NEXT_LINE;
               cmd = 1'b1;
            end else begin
               last = (pos_ff == 4'd14);
            end
         end
         afmt_pkg::MODE_VOLT: begin
            if (pos_ff == 4'd1) begin
               ch = afmt_pkg::CHAR_POINT;
            end else begin
               ch       = afmt_pkg::CHAR_ZERO + 8'(quo);
               rem_step = VB'(div_t - div_sub);
            end
            last = (pos_ff == 4'(item_ff.places) + 4'd1);
         end
      endcase
   end

   assign step  = busy_ff && (!out_valid_ff || rsp_chan.ready);
   assign q_pop = q_head.valid && (!busy_ff || (step && last));

   always_comb begin
      busy_in    = busy_ff;
      item_in    = item_ff;
      pos_in     = pos_ff;
      rem_in     = rem_ff;
      started_in = started_ff;
      if (step) begin
         pos_in     = pos_ff + 4'd1;
         rem_in     = rem_step;
         started_in = started_step;
         if (last) begin
            busy_in = 1'b0;
         end
      end
      if (q_pop) begin
         busy_in    = 1'b1;
         item_in    = q_head.item;
         pos_in     = '0;
         rem_in     = q_head.item.value;
         started_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_char_in  = out_char_ff;
      out_cmd_in   = out_cmd_ff;
      out_last_in  = out_last_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_char_in  = ch;
         out_cmd_in   = cmd;
         out_last_in  = last;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.char_code  = out_char_ff;
   assign rsp_chan.is_command = out_cmd_ff;
   assign rsp_chan.last_char  = out_last_ff;

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      pos_ff      <= pos_in;
      rem_ff      <= rem_in;
      started_ff  <= started_in;
      out_char_ff <= out_char_in;
      out_cmd_ff  <= out_cmd_in;
      out_last_ff <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/adc_pair_average_ascii_formatter_top.sv
// top level of the adc pair average ascii formatter
`timescale 1ns / 1ps
`default_nettype none

// channel     direction  transfer payload
// ----------  ---------  ------------------------------------------------
// req_chan    in         sample_high[7:0], sample_low[1:0]
// rsp_chan    out        char_code[7:0], is_command, last_char
// csr_*       in         csr_index[1:0], csr_wdata[2:0] on csr_wr_en
//
// the back end emits one character per cycle while the sink does not stall:
// 4 for hex, 5 for decimal, 15 for binary and places+2 for voltage text;
// the next value starts on the cycle after the last character
// on an idle block the pair's average passes the queue slot, the back end's
// item register and the output register before its first character is offered
// a first sample of a pair is taken at once; a second one waits only while
// the two-entry value queue is full; a character held in the output register
// while the sink stalls holds the back end as well
// synchronous reset clears control state and the held sample only; no clearing pass is needed

module adc_pair_average_ascii_formatter_top #(
   parameter int SAMPLE_BITS = afmt_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   afmt_req_if.sink                                 req_chan,
   afmt_rsp_if.source                               rsp_chan,
   input  wire logic                                csr_wr_en,
   input  wire logic [afmt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [afmt_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // front to queue and queue to back
   afmt_pkg::q_port_type q_push;
   afmt_pkg::q_port_type q_head;
   logic                 q_full;
   logic                 q_pop;

   // pairing, averaging and config registers
   afmt_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_full    (q_full),
      .q_push    (q_push)
   );

   // decouples averaging from the slow character stream
   afmt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_head (q_head)
   );

   // character sequencer with registered output
   afmt_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

// File: verif/adc_pair_average_ascii_formatter_top_test.sv
// self-checking testbench of the adc pair average ascii formatter top level
`timescale 1ns / 1ps

module adc_pair_average_ascii_formatter_top_test;

   localparam int SAMPLE_BITS = afmt_pkg::SAMPLE_BITS_DEFAULT;
   localparam int unsigned SAMPLE_MASK = (1 << SAMPLE_BITS) - 1;

   // register indexes with no register behind them; writes there must do nothing
   localparam logic [afmt_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [afmt_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   // a pair is at most fifteen characters; this covers an empty voltage pair too
   localparam int DRAIN_CYCLES = 32;
   // random part on top of the directed samples
   localparam int RANDOM_ITEMS = 84;
   localparam int TIMEOUT_NS   = 2_000_000;

   // one character the block should send
   typedef struct {
      logic [7:0] code;
      logic       cmd;
      logic       last;
   } char_rec_type;

   // tracks the pairing state and config, and keeps the characters still owed
   class pair_text_model;
      logic [1:0]             mode;
      logic [2:0]             places;
      logic [SAMPLE_BITS-1:0] held;
      bit                     have_first;
      char_rec_type           chars_due[$];
      int                     errors;

      function new();
         mode       = afmt_pkg::MODE_RESET;
         places     = afmt_pkg::PLACES_RESET;
         held       = '0;
         have_first = 1'b0;
         errors     = 0;
      endfunction

      function void set_reg(logic [afmt_pkg::CSR_INDEX_BITS-1:0] index,
                            logic [afmt_pkg::CSR_DATA_BITS-1:0] data);
         if (index == afmt_pkg::CSR_DISPLAY_MODE) begin
            mode = data[1:0];
         end else if (index == afmt_pkg::CSR_VOLT_PLACES) begin
            places = data;
         end
      endfunction

      function int pending();
         return chars_due.size();
      endfunction

      function void push(logic [7:0] code, logic cmd = 1'b0);
         char_rec_type rec;
         rec.code = code;
         rec.cmd  = cmd;
         rec.last = 1'b0;
         chars_due.push_back(rec);
      endfunction

      function logic [7:0] hex_digit(int unsigned nib);
         nib = nib & 4'hF;
         if (nib >= 10) nib = nib + afmt_pkg::HEX_ALPHA_GAP;
         return 8'(afmt_pkg::CHAR_ZERO + nib);
      endfunction

      // called on every accepted sample; a second sample queues the pair's text
      function void take_sample(logic [7:0] high, logic [1:0] low);
         int unsigned smp, avg, scale, kk, pw, dig;
         int          first_new;
         bit          lead;
         smp = ((int'(high) << 2) + low) & SAMPLE_MASK;
         if (!have_first) begin
            held       = SAMPLE_BITS'(smp);
            have_first = 1'b1;
            return;
         end
         have_first = 1'b0;
         avg        = ((held + smp) >> 1) & SAMPLE_MASK;
         first_new  = chars_due.size();
         case (mode)
            afmt_pkg::MODE_HEX: begin
               push(hex_digit(avg >> 8));
               push(hex_digit(avg >> 4));
               push(hex_digit(avg));
               push(afmt_pkg::CHAR_SPACE);
            end
            afmt_pkg::MODE_DEC: begin
               pw   = 1000;
               lead = 1'b1;
               for (int i = 0; i < 4; i++) begin
                  dig = (avg / pw) % 10;
                  // ones digit always shows, even for zero
                  if (dig != 0 || i == 3) lead = 1'b0;
                  push(lead ? afmt_pkg::CHAR_SPACE : 8'(afmt_pkg::CHAR_ZERO + dig));
                  pw = pw / 10;
               end
               push(afmt_pkg::CHAR_SPACE);
            end
            afmt_pkg::MODE_BIN: begin
               for (int b = afmt_pkg::VAL_BITS - 1; b >= 0; b--) begin
                  push(8'(afmt_pkg::CHAR_ZERO + ((avg >> b) & 1)));
               end
               push(afmt_pkg::CMD_NEXT_LINE, 1'b1);
               push(afmt_pkg::CHAR_SPACE);
               push(afmt_pkg::CHAR_SPACE);
            end
            default: begin
               // out-of-range place count swallows the pair silently
               if (places >= afmt_pkg::PLACES_MIN && places <= afmt_pkg::PLACES_MAX) begin
                  scale = 1;
                  for (int i = 0; i < places; i++) scale = scale * 10;
                  kk = (avg * afmt_pkg::VOLT_GAIN * scale) / afmt_pkg::VOLT_FULL_SCALE;
                  push(8'(afmt_pkg::CHAR_ZERO + kk / scale));
                  push(afmt_pkg::CHAR_POINT);
                  for (int i = 0; i < places; i++) begin
                     scale = scale / 10;
                     push(8'(afmt_pkg::CHAR_ZERO + (kk / scale) % 10));
                  end
               end
            end
         endcase
         if (chars_due.size() > first_new) chars_due[$].last = 1'b1;
      endfunction

      function void check_char(logic [7:0] code, logic cmd, logic last);
         char_rec_type want;
         if (chars_due.size() == 0) begin
            $error("unexpected character 0x%02h with nothing outstanding", code);
            errors++;
            return;
         end
         want = chars_due.pop_front();
         if (code !== want.code) begin
            $error("char_code: expected 0x%02h, got 0x%02h", want.code, code);
            errors++;
         end
         if (cmd !== want.cmd) begin
            $error("is_command: expected %0b, got %0b", want.cmd, cmd);
            errors++;
         end
         if (last !== want.last) begin
            $error("last_char: expected %0b, got %0b", want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                                csr_wr_en;
   logic [afmt_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [afmt_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   afmt_req_if req_chan ();
   afmt_rsp_if rsp_chan ();

   pair_text_model text_model = new();

   // when set, the sample side sends back to back for the current phase
   bit req_calm;

   adc_pair_average_ascii_formatter_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(TIMEOUT_NS);
      $display("adc_pair_average_ascii_formatter_top verification failed");
      $finish;
   end

   // one sample transfer; valid stays high on return so a back-to-back
   // sample can follow in the same step without a glitch
   task automatic send_sample(logic [7:0] high, logic [1:0] low);
      int unsigned gap;
      gap = req_calm ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.sample_high <= high;
      req_chan.sample_low  <= low;
      do @(posedge clock); while (!req_chan.ready);
      text_model.take_sample(high, low);
   endtask

   // random sample byte, with the rails showing up more often
   function automatic logic [7:0] pick_high();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // write enable is left high; the caller drops it after the last write
   task automatic write_reg(logic [afmt_pkg::CSR_INDEX_BITS-1:0] index,
                            logic [afmt_pkg::CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      text_model.set_reg(index, data);
   endtask

   // quiesce the block, then load a new mode and place count, optionally also writing the spare indexes
   task automatic configure(logic [afmt_pkg::CSR_DATA_BITS-1:0] mode_data,
                            logic [afmt_pkg::CSR_DATA_BITS-1:0] places_data, bit spare);
      req_chan.valid <= 1'b0;
      while (text_model.pending() != 0) @(posedge clock);
      // an empty voltage pair may still be in flight with nothing owed
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_reg(afmt_pkg::CSR_DISPLAY_MODE, mode_data);
      write_reg(afmt_pkg::CSR_VOLT_PLACES, places_data);
      if (spare) begin
         write_reg(CSR_SPARE_A, 3'($urandom_range(0, 7)));
         write_reg(CSR_SPARE_B, 3'($urandom_range(0, 7)));
      end
      csr_wr_en <= 1'b0;
   endtask

   // character sink: random stall before each transfer, with calm stretches
   initial begin : char_sink
      int unsigned stall;
      int unsigned calm;
      calm = 0;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (calm != 0) begin
            stall = 0;
            calm--;
         end else begin
            if ($urandom_range(0, 3) == 0) calm = $urandom_range(10, 40);
            stall = $urandom_range(0, 19);
         end
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         text_model.check_char(rsp_chan.char_code, rsp_chan.is_command, rsp_chan.last_char);
      end
   end

   initial begin : stimulus
      int          sent;
      int unsigned count;
      logic [2:0]  places_pick;

      reset                <= 1'b1;
      req_chan.valid       <= 1'b0;
      req_chan.sample_high <= '0;
      req_chan.sample_low  <= '0;
      csr_wr_en            <= 1'b0;
      csr_index            <= '0;
      csr_wdata            <= '0;
      req_calm             = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset config is hex: all zeros, then full scale for the letter digits
      send_sample(8'h00, 2'd0);
      send_sample(8'h00, 2'd0);
      send_sample(8'hFF, 2'd3);
      send_sample(8'hFF, 2'd3);

      // decimal: zero with the round-down of an odd sum, near full scale,
      // and a single digit with leading blanks
      configure({1'b0, afmt_pkg::MODE_DEC}, afmt_pkg::PLACES_RESET, 1'b0);
      send_sample(8'h00, 2'd0);
      send_sample(8'h00, 2'd1);
      send_sample(8'hFF, 2'd3);
      send_sample(8'hFF, 2'd2);
      send_sample(8'h02, 2'd2);
      send_sample(8'h00, 2'd3);

      // binary with the line command, alternating bit patterns
      configure({1'b0, afmt_pkg::MODE_BIN}, afmt_pkg::PLACES_RESET, 1'b0);
      send_sample(8'hAA, 2'd2);
      send_sample(8'h55, 2'd1);

      // voltage at both place extremes
      configure({1'b0, afmt_pkg::MODE_VOLT}, afmt_pkg::PLACES_MAX, 1'b0);
      send_sample(8'hFF, 2'd3);
      send_sample(8'hFF, 2'd3);
      configure({1'b0, afmt_pkg::MODE_VOLT}, afmt_pkg::PLACES_MIN, 1'b0);
      send_sample(8'h00, 2'd0);
      send_sample(8'h00, 2'd1);

      // place counts out of range: the pair yields no text
      configure({1'b0, afmt_pkg::MODE_VOLT}, 3'd0, 1'b0);
      send_sample(8'h80, 2'd0);
      send_sample(8'h40, 2'd2);
      configure({1'b0, afmt_pkg::MODE_VOLT}, 3'd7, 1'b0);
      send_sample(8'hC3, 2'd1);
      send_sample(8'h3C, 2'd2);

      // writes to the unused indexes must leave voltage text untouched
      configure({1'b0, afmt_pkg::MODE_VOLT}, afmt_pkg::PLACES_MAX, 1'b1);
      send_sample(8'h64, 2'd1);
      send_sample(8'hC8, 2'd2);

      // random phases: new config each time, odd lengths carry a held
      // sample across the config change
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            places_pick = 3'($urandom_range(0, 7));
         end else begin
            places_pick = 3'($urandom_range(afmt_pkg::PLACES_MIN, afmt_pkg::PLACES_MAX));
         end
         configure(3'($urandom_range(0, 7)), places_pick, $urandom_range(0, 4) == 0);
         req_calm = ($urandom_range(0, 3) == 0);
         count    = $urandom_range(4, 16);
         repeat (count) begin
            send_sample(pick_high(), 2'($urandom_range(0, 3)));
            sent++;
         end
      end

      // drain and give stray characters a chance to show up
      req_chan.valid <= 1'b0;
      while (text_model.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (text_model.errors == 0) begin
         $display("adc_pair_average_ascii_formatter_top verification clean");
      end else begin
         $display("adc_pair_average_ascii_formatter_top verification failed");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/afmt_pkg.sv
rtl/afmt_if.sv
rtl/afmt_front.sv
rtl/afmt_queue.sv
rtl/afmt_back.sv
rtl/adc_pair_average_ascii_formatter_top.sv
verif/adc_pair_average_ascii_formatter_top_test.sv
